[design/lpft_pkg.sv]
// Shared types, constants and the angle-table helper for the lidar point filter.
`default_nettype none

package lpft_pkg;

  // Field widths of one point and of one result.
  localparam int COORD_W = 19;
  localparam int INTEN_W = 16;
  localparam int OFFS_W  = 20;
  localparam int DRAW_W  = 16;
  localparam int TIME_W  = 21;

  // Register widths.
  localparam int RATIO_W = 17;
  localparam int DIST_W  = 18;
  localparam int UPR_W   = 20;

  // Range arithmetic: a coordinate square needs 37 bits, the sum of three 38 bits.
  localparam int SQ_W   = 2 * COORD_W - 1;
  localparam int SUM_W  = SQ_W + 1;
  localparam int DSQ_W  = 2 * DIST_W;

  // CORDIC datapath: coordinates scaled by 2^20, with headroom for the gain.
  localparam int CORDIC_SHIFT = 20;
  localparam int XW           = 42;

  // Stream and configuration port widths.
  localparam int S_TDATA_W  = 112;
  localparam int M_TDATA_W  = 80;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Defaults for the top-level parameters.
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int CORDIC_STAGES_DEF   = 16;

  // Arctangent table and pi in Q30.
  localparam int ATAN_LEN = 24;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

  // Register reset values.
  localparam logic [INTEN_W-1:0] MIN_INTENSITY_RST = '0;
  localparam logic [RATIO_W-1:0] KEEP_RATIO_RST    = 17'd65536;
  localparam logic [DIST_W-1:0]  MIN_DIST_RST      = '0;
  localparam logic [DIST_W-1:0]  MAX_DIST_RST      = 18'd262143;
  localparam logic [UPR_W-1:0]   US_PER_RAD_RST    = 20'd31831;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_INTENSITY  = 3'd0,
    REG_KEEP_RATIO     = 3'd1,
    REG_MIN_DIST       = 3'd2,
    REG_MAX_DIST       = 3'd3,
    REG_ESTIMATE_TIMES = 3'd4,
    REG_CLOCKWISE      = 3'd5,
    REG_US_PER_RADIAN  = 3'd6
  } cfg_reg_e;

  // All configuration registers as one bundle.
  typedef struct packed {
    logic [INTEN_W-1:0] min_intensity;
    logic [RATIO_W-1:0] keep_ratio_q16;
    logic [DIST_W-1:0]  min_dist_mm;
    logic [DIST_W-1:0]  max_dist_mm;
    logic               estimate_times;
    logic               clockwise;
    logic [UPR_W-1:0]   us_per_radian;
  } cfg_t;

  // The part of a point that travels with it down the pipeline.
  typedef struct packed {
    logic signed [COORD_W-1:0] x_mm;
    logic signed [COORD_W-1:0] y_mm;
    logic signed [COORD_W-1:0] z_mm;
    logic [OFFS_W-1:0]         offset_us;
  } point_t;

  // Rounds a Q30 angle to the given number of fraction bits.
  function automatic logic [31:0] to_angle(logic [31:0] q30, int frac_bits);
    logic [32:0] sum;
    sum = {1'b0, q30} + (33'd1 << (29 - frac_bits));
    return 32'(sum >> (30 - frac_bits));
  endfunction

endpackage

`default_nettype wire

[design/lpft_prep.sv]
// Front stages: intensity and draw tests, squared range window and CORDIC pre-rotation.
`default_nettype none

module lpft_prep
  import lpft_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire cfg_t                                cfg,
  input  wire logic                                in_valid,
  input  wire point_t                              in_pt,
  input  wire logic [INTEN_W-1:0]                  in_intensity,
  input  wire logic [DRAW_W-1:0]                   in_keep_draw,
  output logic                                     out_valid,
  output point_t                                   out_pt,
  output logic signed [XW-1:0]                     out_xv,
  output logic signed [XW-1:0]                     out_yv,
  output logic signed [ANGLE_FRAC_BITS+3:0]        out_z,
  output logic                                     out_origin
);

  localparam int ZW = ANGLE_FRAC_BITS + 4;
  localparam logic signed [ZW-1:0] PI_A = ZW'(to_angle(PI_Q30, ANGLE_FRAC_BITS));
  localparam int EXT_W = XW - COORD_W - CORDIC_SHIFT;

  // Stage A registers.
  logic                    vld_a;
  logic                    ok_a;
  logic [SQ_W-1:0]         xx_a, yy_a, zz_a;
  logic [DSQ_W-1:0]        minsq_a, maxsq_a;
  point_t                  pt_a;
  logic signed [XW-1:0]    xv_a, yv_a;
  logic signed [ZW-1:0]    z_a;
  logic                    org_a;

  // Stage B registers.
  logic                    vld_b;
  logic                    ok_b;
  logic [SUM_W-1:0]        sum_b;
  logic [DSQ_W-1:0]        minsq_b, maxsq_b;
  point_t                  pt_b;
  logic signed [XW-1:0]    xv_b, yv_b;
  logic signed [ZW-1:0]    z_b;
  logic                    org_b;

  // Stage A next values.
  logic signed [2*COORD_W-1:0] px, py, pz;
  logic                        ok_a_next;
  logic signed [XW-1:0]        xs, ys;
  logic signed [XW-1:0]        xv_a_next, yv_a_next;
  logic signed [ZW-1:0]        z_a_next;
  logic [DSQ_W-1:0]            minsq_a_next, maxsq_a_next;
  logic                        in_range;

  // Squares, threshold tests and the turn by pi for the left half plane.
  always_comb begin
    px = in_pt.x_mm * in_pt.x_mm;
    py = in_pt.y_mm * in_pt.y_mm;
    pz = in_pt.z_mm * in_pt.z_mm;
    minsq_a_next = cfg.min_dist_mm * cfg.min_dist_mm;
    maxsq_a_next = cfg.max_dist_mm * cfg.max_dist_mm;
    ok_a_next = (in_intensity > cfg.min_intensity) &&
                ({1'b0, in_keep_draw} < cfg.keep_ratio_q16);
    xs = {{EXT_W{in_pt.y_mm[COORD_W-1]}}, in_pt.y_mm, {CORDIC_SHIFT{1'b0}}};
    ys = {{EXT_W{in_pt.x_mm[COORD_W-1]}}, in_pt.x_mm, {CORDIC_SHIFT{1'b0}}};
    if (in_pt.y_mm[COORD_W-1]) begin
      xv_a_next = -xs;
      yv_a_next = -ys;
      z_a_next  = in_pt.x_mm[COORD_W-1] ? -PI_A : PI_A;
    end else begin
      xv_a_next = xs;
      yv_a_next = ys;
      z_a_next  = '0;
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a     <= 1'b0;
      vld_b     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_a     <= in_valid;
      vld_b     <= vld_a;
      out_valid <= vld_b && ok_b && in_range;
    end
  end

  // Stage A payload.
  always_ff @(posedge clk) begin
    if (en) begin
      ok_a    <= ok_a_next;
      xx_a    <= px[SQ_W-1:0];
      yy_a    <= py[SQ_W-1:0];
      zz_a    <= pz[SQ_W-1:0];
      minsq_a <= minsq_a_next;
      maxsq_a <= maxsq_a_next;
      pt_a    <= in_pt;
      xv_a    <= xv_a_next;
      yv_a    <= yv_a_next;
      z_a     <= z_a_next;
      org_a   <= (in_pt.x_mm == '0) && (in_pt.y_mm == '0);
    end
  end

  // Stage B: sum of the squares.
  always_ff @(posedge clk) begin
    if (en) begin
      ok_b    <= ok_a;
      sum_b   <= SUM_W'(xx_a) + SUM_W'(yy_a) + SUM_W'(zz_a);
      minsq_b <= minsq_a;
      maxsq_b <= maxsq_a;
      pt_b    <= pt_a;
      xv_b    <= xv_a;
      yv_b    <= yv_a;
      z_b     <= z_a;
      org_b   <= org_a;
    end
  end

  // Stage C: strict range window; a point outside it leaves as a bubble.
  assign in_range = (sum_b > SUM_W'(minsq_b)) && (sum_b < SUM_W'(maxsq_b));

  always_ff @(posedge clk) begin
    if (en) begin
      out_pt     <= pt_b;
      out_xv     <= xv_b;
      out_yv     <= yv_b;
      out_z      <= z_b;
      out_origin <= org_b;
    end
  end

  a_range_drop: assert property (@(posedge clk) disable iff (rst)
    (en && vld_b && !in_range) |=> !out_valid)
    else $error("point outside the range window passed stage C");

  a_tests_drop: assert property (@(posedge clk) disable iff (rst)
    (en && vld_b && !ok_b) |=> !out_valid)
    else $error("point failing intensity or draw test passed stage C");

endmodule

`default_nettype wire

[design/lpft_cordic.sv]
// Pipelined CORDIC in vectoring mode: one rotation per stage gives atan2(x, y).
`default_nettype none

module lpft_cordic
  import lpft_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire point_t                            in_pt,
  input  wire logic signed [XW-1:0]              in_xv,
  input  wire logic signed [XW-1:0]              in_yv,
  input  wire logic signed [ANGLE_FRAC_BITS+3:0] in_z,
  input  wire logic                              in_origin,
  output logic                                   out_valid,
  output point_t                                 out_pt,
  output logic signed [ANGLE_FRAC_BITS+3:0]      out_z,
  output logic                                   out_origin
);

  localparam int ZW = ANGLE_FRAC_BITS + 4;

  // Stage 0 is the input; stage i+1 holds the result of rotation i.
  logic                 vld [0:CORDIC_STAGES];
  point_t               pt  [0:CORDIC_STAGES];
  logic signed [XW-1:0] xv  [0:CORDIC_STAGES];
  logic signed [XW-1:0] yv  [0:CORDIC_STAGES];
  logic signed [ZW-1:0] zv  [0:CORDIC_STAGES];
  logic                 org [0:CORDIC_STAGES];

  assign vld[0] = in_valid;
  assign pt[0]  = in_pt;
  assign xv[0]  = in_xv;
  assign yv[0]  = in_yv;
  assign zv[0]  = in_z;
  assign org[0] = in_origin;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN_A = ZW'(to_angle(ATAN_Q30[i], ANGLE_FRAC_BITS));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    // Rotate toward the x axis and accumulate the angle.
    always_ff @(posedge clk) begin
      if (en) begin
        pt[i+1]  <= pt[i];
        org[i+1] <= org[i];
        if (!yv[i][XW-1]) begin
          xv[i+1] <= xv[i] + (yv[i] >>> i);
          yv[i+1] <= yv[i] - (xv[i] >>> i);
          zv[i+1] <= zv[i] + ATAN_A;
        end else begin
          xv[i+1] <= xv[i] - (yv[i] >>> i);
          yv[i+1] <= yv[i] + (xv[i] >>> i);
          zv[i+1] <= zv[i] - ATAN_A;
        end
      end
    end
  end

  assign out_valid  = vld[CORDIC_STAGES];
  assign out_pt     = pt[CORDIC_STAGES];
  assign out_z      = zv[CORDIC_STAGES];
  assign out_origin = org[CORDIC_STAGES];

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    (en && !vld[CORDIC_STAGES-1]) |=> !vld[CORDIC_STAGES])
    else $error("CORDIC output valid without an item in the stage before");

endmodule

`default_nettype wire

[design/lpft_time.sv]
// Back stages: angle limit, scaling to microseconds, saturation and the output register.
`default_nettype none

module lpft_time
  import lpft_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire cfg_t                              cfg,
  input  wire logic                              in_valid,
  input  wire point_t                            in_pt,
  input  wire logic signed [ANGLE_FRAC_BITS+3:0] in_z,
  input  wire logic                              in_origin,
  output logic                                   out_valid,
  output point_t                                 out_pt,
  output logic signed [TIME_W-1:0]               out_time
);

  localparam int ZW     = ANGLE_FRAC_BITS + 4;
  localparam int MAG_W  = ANGLE_FRAC_BITS + 3;
  localparam int PROD_W = MAG_W + UPR_W;
  localparam int RND_W  = PROD_W - ANGLE_FRAC_BITS;
  localparam logic [MAG_W-1:0]  ANGLE_LIMIT = MAG_W'(3 << ANGLE_FRAC_BITS);
  localparam logic [PROD_W-1:0] HALF_LSB    = PROD_W'(1) << (ANGLE_FRAC_BITS - 1);
  localparam logic [RND_W-1:0]  POS_LIMIT   = RND_W'((1 << (TIME_W - 1)) - 1);
  localparam logic [RND_W-1:0]  NEG_LIMIT   = RND_W'(1 << (TIME_W - 1));
  localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

  // Stage 1: magnitude and sign of the angle.
  logic               vld1;
  logic               neg1;
  logic [MAG_W-1:0]   mag1;
  point_t             pt1;

  // Stage 2: scaled magnitude.
  logic               vld2;
  logic               neg2;
  logic [PROD_W-1:0]  prod2;
  point_t             pt2;

  logic signed [ZW-1:0]    ang;
  logic signed [ZW-1:0]    ang_abs;
  logic [MAG_W-1:0]        mag1_next;
  logic                    drop1_next;
  logic [PROD_W-1:0]       psum;
  logic [RND_W-1:0]        rnd;
  logic [RND_W-1:0]        rnd_neg;
  logic signed [TIME_W-1:0] sat;
  logic signed [TIME_W-1:0] time_next;

  // The origin has azimuth zero; angles beyond 3 rad are dropped in estimate mode.
  always_comb begin
    ang        = in_origin ? '0 : in_z;
    ang_abs    = ang[ZW-1] ? -ang : ang;
    mag1_next  = ang_abs[MAG_W-1:0];
    drop1_next = cfg.estimate_times && (mag1_next > ANGLE_LIMIT);
  end

  // Round half up on the magnitude, apply the sign, then saturate.
  always_comb begin
    psum    = prod2 + HALF_LSB;
    rnd     = psum[PROD_W-1:ANGLE_FRAC_BITS];
    rnd_neg = -rnd;
    if (neg2) begin
      sat = (rnd > NEG_LIMIT) ? TIME_MIN : rnd_neg[TIME_W-1:0];
    end else begin
      sat = (rnd > POS_LIMIT) ? TIME_MAX : rnd[TIME_W-1:0];
    end
    time_next = cfg.estimate_times ? sat : {1'b0, pt2.offset_us};
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld1      <= in_valid && !drop1_next;
      vld2      <= vld1;
      out_valid <= vld2;
    end
  end

  // Payload of stages 1, 2 and the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      neg1     <= ang[ZW-1];
      mag1     <= mag1_next;
      pt1      <= in_pt;
      neg2     <= neg1 ^ !cfg.clockwise;
      prod2    <= PROD_W'(mag1) * PROD_W'(cfg.us_per_radian);
      pt2      <= pt1;
      out_pt   <= pt2;
      out_time <= time_next;
    end
  end

  a_angle_drop: assert property (@(posedge clk) disable iff (rst)
    (en && in_valid && drop1_next) |=> !vld1)
    else $error("point beyond the angle limit entered stage 1");

endmodule

`default_nettype wire

[design/lidar_point_filter_timestamp.sv]
// Top level of the lidar point filter with time-offset assignment.
// Pipeline: three front stages, one CORDIC rotation per stage, three back stages with the output.
// Throughput: one item per cycle; the pipeline stalls as a whole while a result waits.
// Dropped points leave bubbles and produce no result.
// Reset (synchronous, active high) empties the pipeline and loads register defaults.
`default_nettype none

module lidar_point_filter_timestamp
  import lpft_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input point stream.
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // x_mm, y_mm, z_mm, intensity, offset_us, keep_draw, zero fill
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  // Kept point stream.
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // out_x_mm, out_y_mm, out_z_mm, point_time_us, zero fill
  output logic [M_TDATA_W-1:0]       m_tdata,
  // Register write channel.
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ZW = ANGLE_FRAC_BITS + 4;
  localparam int PAD_W = M_TDATA_W - 3 * COORD_W - TIME_W;

  cfg_t                 cfg;
  logic                 en;
  point_t               in_pt;
  logic [INTEN_W-1:0]   in_intensity;
  logic [DRAW_W-1:0]    in_keep_draw;

  logic                 p_valid;
  point_t               p_pt;
  logic signed [XW-1:0] p_xv, p_yv;
  logic signed [ZW-1:0] p_z;
  logic                 p_origin;

  logic                 c_valid;
  point_t               c_pt;
  logic signed [ZW-1:0] c_z;
  logic                 c_origin;

  point_t               o_pt;
  logic signed [TIME_W-1:0] o_time;

  // Configuration registers; writes are taken every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_intensity  <= MIN_INTENSITY_RST;
      cfg.keep_ratio_q16 <= KEEP_RATIO_RST;
      cfg.min_dist_mm    <= MIN_DIST_RST;
      cfg.max_dist_mm    <= MAX_DIST_RST;
      cfg.estimate_times <= 1'b0;
      cfg.clockwise      <= 1'b1;
      cfg.us_per_radian  <= US_PER_RAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        REG_MIN_INTENSITY:  cfg.min_intensity  <= cfg_data[INTEN_W-1:0];
        REG_KEEP_RATIO:     cfg.keep_ratio_q16 <= cfg_data[RATIO_W-1:0];
        REG_MIN_DIST:       cfg.min_dist_mm    <= cfg_data[DIST_W-1:0];
        REG_MAX_DIST:       cfg.max_dist_mm    <= cfg_data[DIST_W-1:0];
        REG_ESTIMATE_TIMES: cfg.estimate_times <= cfg_data[0];
        REG_CLOCKWISE:      cfg.clockwise      <= cfg_data[0];
        REG_US_PER_RADIAN:  cfg.us_per_radian  <= cfg_data[UPR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The whole pipeline advances unless a finished result is held at the output.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Unpack the input item.
  assign in_pt.x_mm      = s_tdata[18:0];
  assign in_pt.y_mm      = s_tdata[37:19];
  assign in_pt.z_mm      = s_tdata[56:38];
  assign in_intensity    = s_tdata[72:57];
  assign in_pt.offset_us = s_tdata[92:73];
  assign in_keep_draw    = s_tdata[108:93];

  lpft_prep #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_prep (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .cfg          (cfg),
    .in_valid     (s_tvalid),
    .in_pt        (in_pt),
    .in_intensity (in_intensity),
    .in_keep_draw (in_keep_draw),
    .out_valid    (p_valid),
    .out_pt       (p_pt),
    .out_xv       (p_xv),
    .out_yv       (p_yv),
    .out_z        (p_z),
    .out_origin   (p_origin)
  );

  lpft_cordic #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .CORDIC_STAGES   (CORDIC_STAGES)
  ) u_cordic (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (p_valid),
    .in_pt      (p_pt),
    .in_xv      (p_xv),
    .in_yv      (p_yv),
    .in_z       (p_z),
    .in_origin  (p_origin),
    .out_valid  (c_valid),
    .out_pt     (c_pt),
    .out_z      (c_z),
    .out_origin (c_origin)
  );

  lpft_time #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_time (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (c_valid),
    .in_pt     (c_pt),
    .in_z      (c_z),
    .in_origin (c_origin),
    .out_valid (m_tvalid),
    .out_pt    (o_pt),
    .out_time  (o_time)
  );

  // Pack the result item.
  assign m_tdata = {{PAD_W{1'b0}}, o_time, o_pt.z_mm, o_pt.y_mm, o_pt.x_mm};

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input held off while the output register is empty");

  a_stall_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while the output is stalled");

endmodule

`default_nettype wire
